FILE: rtl/imd_pkg.sv
`default_nettype none

package imd_pkg;

  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_AVERAGE_BITS = 24;

  localparam int TIME_W     = 64;
  localparam int THR_W      = 15;
  localparam int WARM_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Thresholds are unsigned Q3.12; blend weights are Q0.16 and sum to one.
  localparam int THR_FRAC = 12;
  localparam int W_SHIFT  = 16;
  localparam int W_KEEP   = 64225;
  localparam int W_NEW    = 1311;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 2'd2;

  localparam logic [THR_W-1:0]  GYRO_THR_RST  = 15'd307;
  localparam logic [THR_W-1:0]  ACCEL_THR_RST = 15'd123;
  localparam logic [WARM_W-1:0] WARMUP_RST    = 8'd30;

  typedef enum logic [1:0] {
    SENS_ACC = 2'd0,
    SENS_GYR = 2'd1,
    SENS_MAG = 2'd2
  } sensor_e;

  typedef struct packed {
    logic    capture;
    logic    step;
    sensor_e sensor;
    logic    finish;
  } imd_cmd_t;

  typedef struct packed {
    logic warm_now;
    logic out_free;
  } imd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/imd_if.sv
`default_nettype none

interface imd_sample_if import imd_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [TIME_W-1:0]             sample_time;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic signed [SAMPLE_BITS-1:0] gyro_x;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic signed [SAMPLE_BITS-1:0] gyro_z;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic signed [SAMPLE_BITS-1:0] mag_z;

  modport source (
    output valid, sample_time, accel_x, accel_y, accel_z,
           gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    input  ready
  );
  modport sink (
    input  valid, sample_time, accel_x, accel_y, accel_z,
           gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    output ready
  );
endinterface

interface imd_result_if import imd_pkg::*; #(
  parameter int AVERAGE_BITS = DEF_AVERAGE_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           moved;
  logic                           warming_up;
  logic [TIME_W-1:0]              stationary_ticks;
  logic signed [AVERAGE_BITS-1:0] avg_accel_x;
  logic signed [AVERAGE_BITS-1:0] avg_accel_y;
  logic signed [AVERAGE_BITS-1:0] avg_accel_z;
  logic signed [AVERAGE_BITS-1:0] avg_gyro_x;
  logic signed [AVERAGE_BITS-1:0] avg_gyro_y;
  logic signed [AVERAGE_BITS-1:0] avg_gyro_z;
  logic signed [AVERAGE_BITS-1:0] avg_mag_x;
  logic signed [AVERAGE_BITS-1:0] avg_mag_y;
  logic signed [AVERAGE_BITS-1:0] avg_mag_z;

  modport source (
    output valid, moved, warming_up, stationary_ticks,
           avg_accel_x, avg_accel_y, avg_accel_z,
           avg_gyro_x, avg_gyro_y, avg_gyro_z,
           avg_mag_x, avg_mag_y, avg_mag_z,
    input  ready
  );
  modport sink (
    input  valid, moved, warming_up, stationary_ticks,
           avg_accel_x, avg_accel_y, avg_accel_z,
           avg_gyro_x, avg_gyro_y, avg_gyro_z,
           avg_mag_x, avg_mag_y, avg_mag_z,
    output ready
  );
endinterface

interface imd_cfg_if import imd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/imd_ctrl.sv
`default_nettype none

module imd_ctrl import imd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     smp_valid_i,
  output logic     smp_ready_o,
  input  imd_sts_t sts_i,
  output imd_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_GYR  = 5'b00100,
    ST_MAG  = 5'b01000,
    ST_CMP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign smp_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.sensor  = SENS_ACC;
    cmd_o.finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (smp_valid_i) begin
          cmd_o.capture = 1'b1;
          // Warm-up samples only need the result step.
          state_d = sts_i.warm_now ? ST_CMP : ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.step   = 1'b1;
        cmd_o.sensor = SENS_ACC;
        state_d      = ST_GYR;
      end
      ST_GYR: begin
        cmd_o.step   = 1'b1;
        cmd_o.sensor = SENS_GYR;
        state_d      = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.step   = 1'b1;
        cmd_o.sensor = SENS_MAG;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_valid_i && smp_ready_o) |=> (state_q == ST_ACC || state_q == ST_CMP))
    else $error("accepted sample did not start processing");

  a_cmp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && !sts_i.out_free) |=> (state_q == ST_CMP))
    else $error("result step left while output register was full");

  a_one_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !cmd_o.capture)
    else $error("two samples captured in consecutive cycles");

endmodule

`default_nettype wire

FILE: rtl/imd_datapath.sv
`default_nettype none

module imd_datapath import imd_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int AVERAGE_BITS = DEF_AVERAGE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  imd_cmd_t     cmd_i,
  output imd_sts_t     sts_o,
  imd_sample_if.sink   smp_i,
  imd_result_if.source res_o,
  imd_cfg_if.sink      cfg_i
);

  localparam int SB      = SAMPLE_BITS;
  localparam int AB      = AVERAGE_BITS;
  localparam int BACC_W  = AB + 18;
  localparam int SQ_IN_W = (AB + 1 > SB) ? AB + 1 : SB;
  localparam int SQ_W    = 2 * SQ_IN_W - 1;
  localparam int SUM_W   = SQ_W + 2;

  localparam logic signed [17:0] KEEP_S = 18'(W_KEEP);
  localparam logic signed [17:0] NEW_S  = 18'(W_NEW);
  localparam logic signed [17:0] RND_S  = 18'(1 << (W_SHIFT - 1));

  // Exact move from the sample scale to the average scale (floor when narrowing).
  function automatic logic signed [AB-1:0] to_avg(input logic signed [SB-1:0] s);
    logic [SB+AB-1:0] cat;
    cat = {s, {AB{1'b0}}};
    return $signed(cat[SB+AB-1 -: AB]);
  endfunction

  logic [THR_W-1:0]  gthr_q, athr_q;
  logic [WARM_W-1:0] warm_left_q;
  logic              warming_q, valid_q;
  logic [TIME_W-1:0] time_q, last_move_q;

  logic signed [SB-1:0] acc_s_q [3];
  logic signed [SB-1:0] gyr_s_q [3];
  logic signed [SB-1:0] mag_s_q [3];
  logic signed [AB-1:0] acc_avg_q [3];
  logic signed [AB-1:0] gyr_avg_q [3];
  logic signed [AB-1:0] mag_avg_q [3];
  logic [SQ_W-1:0]      gsq_q [3];
  logic [SQ_W-1:0]      dsq_q [3];
  logic [SQ_W-1:0]      gt_sq_q, at_sq_q;

  logic                 res_valid_q, res_moved_q, res_warm_q;
  logic [TIME_W-1:0]    res_stat_q;
  logic signed [AB-1:0] res_acc_q [3];
  logic signed [AB-1:0] res_gyr_q [3];
  logic signed [AB-1:0] res_mag_q [3];

  logic signed [AB-1:0] lane_avg [3];
  logic [SQ_W-1:0]      lane_sq [3];

  logic                  cfg_fire;
  logic [THR_W+SB-5:0]   gt_cat;
  logic [THR_W+AB-5:0]   at_cat;
  logic [SB-2:0]         gt_val;
  logic [AB-2:0]         at_val;

  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign sts_o.warm_now = (warm_left_q != '0);
  assign sts_o.out_free = !res_valid_q || res_o.ready;

  // Thresholds moved to the scale of the quantity they are compared against.
  assign gt_cat = {gthr_q, {(SB-4){1'b0}}};
  assign at_cat = {athr_q, {(AB-4){1'b0}}};
  assign gt_val = gt_cat[THR_W+SB-5:THR_FRAC];
  assign at_val = at_cat[THR_W+AB-5:THR_FRAC];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [SB-1:0]        smp;
    logic signed [AB-1:0]        avg, smp_avg, acc_smp_avg, new_avg;
    logic signed [BACC_W-1:0]    bacc;
    logic signed [AB+1:0]        shr;
    logic signed [AB:0]          acc_dev;
    logic signed [SQ_IN_W-1:0]   sq_in;
    logic signed [2*SQ_IN_W-1:0] sq_full;

    always_comb begin
      case (cmd_i.sensor)
        SENS_GYR: begin
          smp = gyr_s_q[i];
          avg = gyr_avg_q[i];
        end
        SENS_MAG: begin
          smp = mag_s_q[i];
          avg = mag_avg_q[i];
        end
        default: begin
          smp = acc_s_q[i];
          avg = acc_avg_q[i];
        end
      endcase
    end

    assign smp_avg     = to_avg(smp);
    assign acc_smp_avg = to_avg(acc_s_q[i]);

    // Blend with round half up, then saturate to the average width.
    assign bacc = avg * KEEP_S + smp_avg * NEW_S + RND_S;
    assign shr  = bacc[BACC_W-1:W_SHIFT];

    always_comb begin
      if ((&shr[AB+1:AB-1]) || !(|shr[AB+1:AB-1])) begin
        new_avg = shr[AB-1:0];
      end else if (shr[AB+1]) begin
        new_avg = {1'b1, {(AB-1){1'b0}}};
      end else begin
        new_avg = {1'b0, {(AB-1){1'b1}}};
      end
    end

    // The first sample past warm-up loads the averages exactly.
    assign lane_avg[i] = valid_q ? new_avg : smp_avg;

    assign acc_dev = $signed({acc_avg_q[i][AB-1], acc_avg_q[i]})
                   - $signed({acc_smp_avg[AB-1], acc_smp_avg});

    // The squarer is free during the accel step, so it squares the thresholds then.
    always_comb begin
      case (cmd_i.sensor)
        SENS_ACC: begin
          if (i == 0) begin
            sq_in = $signed(SQ_IN_W'(gt_val));
          end else if (i == 1) begin
            sq_in = $signed(SQ_IN_W'(at_val));
          end else begin
            sq_in = '0;
          end
        end
        SENS_GYR: sq_in = SQ_IN_W'(smp);
        SENS_MAG: sq_in = SQ_IN_W'(acc_dev);
        default:  sq_in = '0;
      endcase
    end

    assign sq_full    = sq_in * sq_in;
    assign lane_sq[i] = sq_full[SQ_W-1:0];
  end

  // Result step.
  logic [SUM_W-1:0]  gsum, dsum;
  logic              over, moved, touch, valid_next;
  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] stat;

  assign gsum = SUM_W'(gsq_q[0]) + SUM_W'(gsq_q[1]) + SUM_W'(gsq_q[2]);
  assign dsum = SUM_W'(dsq_q[0]) + SUM_W'(dsq_q[1]) + SUM_W'(dsq_q[2]);
  assign over = (gsum > SUM_W'(gt_sq_q)) || (dsum > SUM_W'(at_sq_q));

  assign moved      = !warming_q && over;
  assign touch      = !warming_q && (over || !valid_q);
  assign valid_next = valid_q || !warming_q;
  assign diff       = {1'b0, time_q} - {1'b0, last_move_q};
  // A timestamp older than the last movement reads as zero ticks.
  assign stat       = (!valid_next || touch || diff[TIME_W]) ? '0 : diff[TIME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gthr_q      <= GYRO_THR_RST;
      athr_q      <= ACCEL_THR_RST;
      warm_left_q <= WARMUP_RST;
      warming_q   <= 1'b0;
      valid_q     <= 1'b0;
      last_move_q <= '0;
      res_valid_q <= 1'b0;
      acc_avg_q   <= '{default: '0};
      gyr_avg_q   <= '{default: '0};
      mag_avg_q   <= '{default: '0};
    end else begin
      if (cfg_fire) begin
        case (cfg_i.index)
          REG_GYRO_THR:  gthr_q      <= cfg_i.data[THR_W-1:0];
          REG_ACCEL_THR: athr_q      <= cfg_i.data[THR_W-1:0];
          REG_WARMUP:    warm_left_q <= cfg_i.data[WARM_W-1:0];
          default: ;
        endcase
      end else if (cmd_i.capture && sts_o.warm_now) begin
        warm_left_q <= warm_left_q - WARM_W'(1);
      end
      if (cmd_i.capture) begin
        warming_q <= sts_o.warm_now;
      end
      if (cmd_i.step) begin
        case (cmd_i.sensor)
          SENS_ACC: acc_avg_q <= lane_avg;
          SENS_GYR: gyr_avg_q <= lane_avg;
          SENS_MAG: mag_avg_q <= lane_avg;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        valid_q <= valid_next;
        if (touch) begin
          last_move_q <= time_q;
        end
      end
      if (cmd_i.finish) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      time_q     <= smp_i.sample_time;
      acc_s_q[0] <= smp_i.accel_x;
      acc_s_q[1] <= smp_i.accel_y;
      acc_s_q[2] <= smp_i.accel_z;
      gyr_s_q[0] <= smp_i.gyro_x;
      gyr_s_q[1] <= smp_i.gyro_y;
      gyr_s_q[2] <= smp_i.gyro_z;
      mag_s_q[0] <= smp_i.mag_x;
      mag_s_q[1] <= smp_i.mag_y;
      mag_s_q[2] <= smp_i.mag_z;
    end
    if (cmd_i.step) begin
      case (cmd_i.sensor)
        SENS_ACC: begin
          gt_sq_q <= lane_sq[0];
          at_sq_q <= lane_sq[1];
        end
        SENS_GYR: begin
          gsq_q <= lane_sq;
        end
        SENS_MAG: begin
          dsq_q <= lane_sq;
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      res_moved_q <= moved;
      res_warm_q  <= warming_q;
      res_stat_q  <= stat;
      res_acc_q   <= acc_avg_q;
      res_gyr_q   <= gyr_avg_q;
      res_mag_q   <= mag_avg_q;
    end
  end

  // The averages start at zero, so the output is defined before loading.
  // Until then valid_q is low and every step loads rather than blends.
  assign res_o.valid            = res_valid_q;
  assign res_o.moved            = res_moved_q;
  assign res_o.warming_up       = res_warm_q;
  assign res_o.stationary_ticks = res_stat_q;
  assign res_o.avg_accel_x      = res_acc_q[0];
  assign res_o.avg_accel_y      = res_acc_q[1];
  assign res_o.avg_accel_z      = res_acc_q[2];
  assign res_o.avg_gyro_x       = res_gyr_q[0];
  assign res_o.avg_gyro_y       = res_gyr_q[1];
  assign res_o.avg_gyro_z       = res_gyr_q[2];
  assign res_o.avg_mag_x        = res_mag_q[0];
  assign res_o.avg_mag_y        = res_mag_q[1];
  assign res_o.avg_mag_z        = res_mag_q[2];

  a_warmup_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && cfg_i.index == REG_WARMUP)
      |=> (warm_left_q == $past(cfg_i.data[WARM_W-1:0])))
    else $error("warm-up counter not reloaded by register write");

  a_warm_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && warming_q) |=> (res_valid_q && res_warm_q && !res_moved_q))
    else $error("warm-up sample reported movement");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |=> (res_valid_q && $stable(res_stat_q)))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

FILE: rtl/imu_motion_detector_unit.sv
`default_nettype none

// IMU motion detector. Each sample transaction on smp_i yields exactly one result
// transaction on res_o, in order. After reset the first warmup_count samples are
// not averaged (warming_up = 1); the next one loads the Q4.20 running averages, and later
// ones blend them as 0.98*avg + 0.02*sample. A sample sets moved when the squared gyro
// norm exceeds the squared gyro threshold or the accel sample lies farther than the
// accel threshold from the new accel average; stationary_ticks counts time since the
// last movement. Registers on cfg_i (always ready): 0 gyro threshold, 1 accel threshold,
// 2 warm-up count, which also restarts the warm-up. A sample passes through the
// accepting cycle, three steps in which three multiply lanes are shared across the
// accel, gyro and magnetometer data, and one step that compares and forms the result;
// during warm-up only the accepting cycle and the result step remain. The output
// register is loaded in the result step, which stalls while an earlier result still
// waits there untaken. The next sample is accepted while a result waits to be taken.
module imu_motion_detector_unit import imd_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int AVERAGE_BITS = DEF_AVERAGE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imd_sample_if.sink   smp_i,
  imd_result_if.source res_o,
  imd_cfg_if.sink      cfg_i
);

  imd_cmd_t cmd;
  imd_sts_t sts;
  logic     smp_ready;

  assign smp_i.ready = smp_ready;

  imd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_i.valid),
    .smp_ready_o (smp_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imd_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .AVERAGE_BITS (AVERAGE_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .smp_i  (smp_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i)
  );

endmodule

`default_nettype wire
